### rtl/core/s2a_pkg.sv
// Shared types, codes and key tables of the scan code line editor.
package s2a_pkg;

  // Default line store size.
  localparam int unsigned LINE_CAPACITY_DEF = 80;

  // Fixed field widths.
  localparam int unsigned OP_W    = 1;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned INDEX_W = 7;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned DIR_W   = 2;

  // Request kinds.
  typedef enum logic [OP_W-1:0] {
    OP_SCAN = 1'b0,
    OP_READ = 1'b1
  } op_e;

  // Cursor move directions.
  typedef enum logic [DIR_W-1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } cursor_dir_e;

  // Scan code set 1 codes.
  localparam logic [CODE_W-1:0] SC_PREFIX       = 8'hE0;
  localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam logic [CODE_W-1:0] SC_BACKSPACE    = 8'h0E;
  localparam logic [CODE_W-1:0] SC_ENTER        = 8'h1C;
  localparam logic [CODE_W-1:0] SC_ARROW_UP     = 8'h48;
  localparam logic [CODE_W-1:0] SC_ARROW_DOWN   = 8'h50;
  localparam logic [CODE_W-1:0] SC_ARROW_LEFT   = 8'h4B;
  localparam logic [CODE_W-1:0] SC_ARROW_RIGHT  = 8'h4D;
  localparam int unsigned       SC_BREAK_BIT    = 7;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_LOWER_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_CASE_BIT  = 8'h20;

  // Decoded result of one request, minus the store read data.
  typedef struct packed {
    logic              echo_valid;
    logic [CHAR_W-1:0] echo_char;
    logic              cursor_valid;
    cursor_dir_e       cursor_dir;
    logic              line_end;
    logic [LEN_W-1:0]  line_length;
    logic              read_sel;
  } result_t;

  // Map a make code to its unshifted Latin-1 character, NUL when unmapped.
  function automatic logic [CHAR_W-1:0] key_map(input logic [CODE_W-2:0] code);
    logic [CHAR_W-1:0] ch;
    ch = CH_NUL;
    unique case (code)
      7'h02: ch = 8'h31;  7'h03: ch = 8'h32;  7'h04: ch = 8'h33;
      7'h05: ch = 8'h34;  7'h06: ch = 8'h35;  7'h07: ch = 8'h36;
      7'h08: ch = 8'h37;  7'h09: ch = 8'h38;  7'h0A: ch = 8'h39;
      7'h0B: ch = 8'h30;
      7'h1E: ch = 8'h61;  7'h30: ch = 8'h62;  7'h2E: ch = 8'h63;
      7'h20: ch = 8'h64;  7'h12: ch = 8'h65;  7'h21: ch = 8'h66;
      7'h22: ch = 8'h67;  7'h23: ch = 8'h68;  7'h17: ch = 8'h69;
      7'h24: ch = 8'h6A;  7'h25: ch = 8'h6B;  7'h26: ch = 8'h6C;
      7'h32: ch = 8'h6D;  7'h31: ch = 8'h6E;  7'h18: ch = 8'h6F;
      7'h19: ch = 8'h70;  7'h10: ch = 8'h71;  7'h13: ch = 8'h72;
      7'h1F: ch = 8'h73;  7'h14: ch = 8'h74;  7'h16: ch = 8'h75;
      7'h2F: ch = 8'h76;  7'h11: ch = 8'h77;  7'h2D: ch = 8'h78;
      7'h15: ch = 8'h79;  7'h2C: ch = 8'h7A;
      7'h1A: ch = 8'hE5;  7'h28: ch = 8'hE4;  7'h27: ch = 8'hF6;
      7'h0C: ch = 8'h2B;  7'h34: ch = 8'h2E;  7'h33: ch = 8'h2C;
      7'h35: ch = 8'h2D;  7'h39: ch = 8'h20;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // Shifted symbol for a make code: {hit, character}.
  function automatic logic [CHAR_W:0] shifted_symbol(input logic [CODE_W-1:0] code);
    logic [CHAR_W:0] sym;
    sym = '0;
    unique case (code)
      8'h02: sym = {1'b1, 8'h21};
      8'h0C: sym = {1'b1, 8'h3F};
      8'h04: sym = {1'b1, 8'h23};
      8'h06: sym = {1'b1, 8'h25};
      8'h09: sym = {1'b1, 8'h28};
      8'h0A: sym = {1'b1, 8'h29};
      8'h35: sym = {1'b1, 8'h5F};
      default: sym = '0;
    endcase
    return sym;
  endfunction

endpackage

### rtl/core/s2a_if.sv
// Request and response channel interfaces of the scan code line editor.
interface s2a_req_if;
  logic                                valid;
  logic                                ready;
  logic [s2a_pkg::OP_W-1:0]            op;
  logic [s2a_pkg::CODE_W-1:0]          scan_code;
  logic [s2a_pkg::INDEX_W-1:0]         read_index;

  modport source (output valid, op, scan_code, read_index, input ready);
  modport sink   (input valid, op, scan_code, read_index, output ready);
endinterface

interface s2a_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                echo_valid;
  logic [s2a_pkg::CHAR_W-1:0]          echo_char;
  logic                                cursor_valid;
  logic [s2a_pkg::DIR_W-1:0]           cursor_dir;
  logic                                line_end;
  logic [s2a_pkg::LEN_W-1:0]           line_length;
  logic [s2a_pkg::CHAR_W-1:0]          read_data;

  modport source (output valid, echo_valid, echo_char, cursor_valid, cursor_dir,
                  line_end, line_length, read_data, input ready);
  modport sink   (input valid, echo_valid, echo_char, cursor_valid, cursor_dir,
                  line_end, line_length, read_data, output ready);
endinterface

### rtl/core/s2a_ram.sv
// Generic single-write, single-read RAM with registered read data.
module s2a_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/s2a_edit.sv
// Decode and line edit logic: flag and count state plus store write control.
module s2a_edit #(
  parameter int unsigned LINE_CAPACITY = s2a_pkg::LINE_CAPACITY_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic [s2a_pkg::OP_W-1:0]           op_i,
  input  logic [s2a_pkg::CODE_W-1:0]         scan_code_i,
  input  logic [s2a_pkg::INDEX_W-1:0]        read_index_i,
  output s2a_pkg::result_t                   result_o,
  output logic                               we_o,
  output logic [$clog2(LINE_CAPACITY)-1:0]   waddr_o,
  output logic [s2a_pkg::CHAR_W-1:0]         wdata_o
);

  localparam int unsigned CntW = $clog2(LINE_CAPACITY + 1);
  localparam int unsigned AddrW = $clog2(LINE_CAPACITY);
  localparam logic [CntW-1:0] CapCnt     = CntW'(LINE_CAPACITY);
  localparam logic [CntW-1:0] CapLessOne = CntW'(LINE_CAPACITY - 1);

  logic            shift_q, shift_d;
  logic            prefix_q, prefix_d;
  logic [CntW-1:0] count_q, count_d;

  logic                        has_room;
  logic                        has_room_mapped;
  logic [s2a_pkg::CHAR_W:0]    sym;
  logic [s2a_pkg::CHAR_W-1:0]  mapped;
  logic                        index_ok;

  assign has_room        = count_q < CapCnt;
  assign has_room_mapped = count_q < CapLessOne;
  assign sym             = s2a_pkg::shifted_symbol(scan_code_i);
  assign mapped          = s2a_pkg::key_map(scan_code_i[s2a_pkg::CODE_W-2:0]);
  assign index_ok        = 32'(read_index_i) < LINE_CAPACITY;
  assign waddr_o         = AddrW'(count_q);

  // Decode one request against the current flags and line length
  always_comb begin
    shift_d  = shift_q;
    prefix_d = prefix_q;
    count_d  = count_q;
    we_o     = 1'b0;
    wdata_o  = s2a_pkg::CH_NUL;
    result_o = '0;
    if (op_i == s2a_pkg::OP_READ) begin
      result_o.read_sel = index_ok;
    end else if (scan_code_i == s2a_pkg::SC_PREFIX) begin
      prefix_d = 1'b1;
    end else if (prefix_q) begin
      prefix_d = 1'b0;
      priority if (scan_code_i == s2a_pkg::SC_ARROW_UP) begin
        result_o.cursor_valid = 1'b1;
        result_o.cursor_dir   = s2a_pkg::DIR_UP;
      end else if (scan_code_i == s2a_pkg::SC_ARROW_DOWN) begin
        result_o.cursor_valid = 1'b1;
        result_o.cursor_dir   = s2a_pkg::DIR_DOWN;
      end else if (scan_code_i == s2a_pkg::SC_ARROW_LEFT) begin
        result_o.cursor_valid = 1'b1;
        result_o.cursor_dir   = s2a_pkg::DIR_LEFT;
      end else if (scan_code_i == s2a_pkg::SC_ARROW_RIGHT) begin
        result_o.cursor_valid = 1'b1;
        result_o.cursor_dir   = s2a_pkg::DIR_RIGHT;
      end else begin
        result_o.cursor_valid = 1'b0;
      end
    end else if (scan_code_i == s2a_pkg::SC_LSHIFT_MAKE ||
                 scan_code_i == s2a_pkg::SC_RSHIFT_MAKE) begin
      shift_d = 1'b1;
    end else if (scan_code_i == s2a_pkg::SC_LSHIFT_BREAK ||
                 scan_code_i == s2a_pkg::SC_RSHIFT_BREAK) begin
      shift_d = 1'b0;
    end else if (scan_code_i[s2a_pkg::SC_BREAK_BIT]) begin
      // drop other key releases
      shift_d = shift_q;
    end else if (scan_code_i == s2a_pkg::SC_BACKSPACE) begin
      if (count_q != '0) begin
        count_d              = count_q - CntW'(1);
        result_o.echo_valid  = 1'b1;
        result_o.echo_char   = s2a_pkg::CH_BACKSPACE;
      end
    end else if (scan_code_i == s2a_pkg::SC_ENTER) begin
      we_o                = has_room;
      wdata_o             = s2a_pkg::CH_NUL;
      result_o.echo_valid = 1'b1;
      result_o.echo_char  = s2a_pkg::CH_NEWLINE;
      result_o.line_end   = 1'b1;
      count_d             = '0;
    end else if (shift_q && sym[s2a_pkg::CHAR_W]) begin
      result_o.echo_valid = 1'b1;
      result_o.echo_char  = sym[s2a_pkg::CHAR_W-1:0];
      we_o                = has_room;
      wdata_o             = sym[s2a_pkg::CHAR_W-1:0];
      if (has_room) begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      result_o.echo_valid = 1'b1;
      result_o.echo_char  = mapped;
      if (shift_q && mapped >= s2a_pkg::CH_LOWER_A && mapped <= s2a_pkg::CH_LOWER_Z) begin
        result_o.echo_char = mapped - s2a_pkg::CH_CASE_BIT;
      end
      we_o    = has_room_mapped;
      wdata_o = result_o.echo_char;
      if (has_room_mapped) begin
        count_d = count_q + CntW'(1);
      end
    end
    result_o.line_length = s2a_pkg::LEN_W'(count_d);
    // only a live request touches the store
    we_o = we_o & en_i;
  end

  // Advance flags and line length on a live request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 1'b0;
      prefix_q <= 1'b0;
      count_q  <= '0;
    end else if (en_i) begin
      shift_q  <= shift_d;
      prefix_q <= prefix_d;
      count_q  <= count_d;
    end
  end

endmodule

### rtl/core/scancode_to_ascii_line_editor.sv
// Top level of the scan code line editor: pipeline registers, line store, checks.
//
// Usage:
//   req_i carries one request per handshake: op 0 feeds a set 1 scan code
//   byte, op 1 reads line store entry read_index. rsp_o returns exactly one
//   response per request, in order: echo character, arrow key direction,
//   end-of-line flag, current line length and, for reads, the stored byte.
//   A request passes through the input register and then the response
//   register: rsp_o.valid rises when the decode results land in the
//   response register together with the line store read port.
//   Throughput is one request per cycle while rsp_o does not stall; the
//   single decode stage that updates shift, prefix and length state sets
//   that rate.
//   When rsp_o stalls, the response register and store read data hold,
//   the input register keeps its request, and req_i.ready drops only once
//   both are full.
//   Reset clears the shift and prefix flags, the line length and all valid
//   bits; the line store is not cleared and needs no clearing pass.
module scancode_to_ascii_line_editor #(
  parameter int unsigned LINE_CAPACITY = s2a_pkg::LINE_CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  s2a_req_if.sink   req_i,
  s2a_rsp_if.source rsp_o
);

  localparam int unsigned AddrW = $clog2(LINE_CAPACITY);

  logic                              s1_valid_q;
  logic [s2a_pkg::OP_W-1:0]          s1_op_q;
  logic [s2a_pkg::CODE_W-1:0]        s1_code_q;
  logic [s2a_pkg::INDEX_W-1:0]       s1_index_q;
  logic                              out_valid_q;
  s2a_pkg::result_t                  out_res_q;
  s2a_pkg::result_t                  s1_res;
  logic                              advance;
  logic                              fire;
  logic                              ram_we;
  logic [AddrW-1:0]                  ram_waddr;
  logic [s2a_pkg::CHAR_W-1:0]        ram_wdata;
  logic [s2a_pkg::CHAR_W-1:0]        ram_rdata;

  // Move when the response slot is free or being taken
  assign advance     = !out_valid_q || rsp_o.ready;
  assign fire        = s1_valid_q && advance;
  assign req_i.ready = !s1_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_op_q    <= req_i.op;
      s1_code_q  <= req_i.scan_code;
      s1_index_q <= req_i.read_index;
    end
  end

  // Decode stage
  s2a_edit #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_edit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (fire),
    .op_i         (s1_op_q),
    .scan_code_i  (s1_code_q),
    .read_index_i (s1_index_q),
    .result_o     (s1_res),
    .we_o         (ram_we),
    .waddr_o      (ram_waddr),
    .wdata_o      (ram_wdata)
  );

  // Line store
  s2a_ram #(
    .WIDTH(s2a_pkg::CHAR_W),
    .DEPTH(LINE_CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (fire),
    .raddr_i (AddrW'(s1_index_q)),
    .rdata_o (ram_rdata)
  );

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= s1_res;
    end
  end

  // Drive response channel
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.echo_valid   = out_res_q.echo_valid;
  assign rsp_o.echo_char    = out_res_q.echo_char;
  assign rsp_o.cursor_valid = out_res_q.cursor_valid;
  assign rsp_o.cursor_dir   = out_res_q.cursor_dir;
  assign rsp_o.line_end     = out_res_q.line_end;
  assign rsp_o.line_length  = out_res_q.line_length;
  assign rsp_o.read_data    = out_res_q.read_sel ? ram_rdata : s2a_pkg::CH_NUL;

`ifndef SYNTHESIS
  a_len_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> 32'(rsp_o.line_length) <= LINE_CAPACITY)
    else $error("line length beyond capacity");

  a_echo_or_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.echo_valid && rsp_o.cursor_valid))
    else $error("echo and cursor move in one response");

  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.line_end) |->
      (rsp_o.line_length == '0 && rsp_o.echo_char == s2a_pkg::CH_NEWLINE))
    else $error("line end without newline or with nonzero length");

  a_no_write_while_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |-> !ram_we)
    else $error("line store written while the pipeline is stalled");
`endif

endmodule
